/* src/auip_pkg.sv */
// Shared types, constants and helpers of the ASCII unsigned integer parser.
package auip_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int OFFSET_BITS = 16;
  localparam int BASE_BITS   = 6;
  localparam int CHAR_BITS   = 8;
  localparam int STATUS_BITS = 2;
  localparam int PROD_BITS   = VALUE_BITS + BASE_BITS;

  localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0] BASE_DEC   = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0] BASE_OCT   = BASE_BITS'(8);
  localparam logic [BASE_BITS-1:0] BASE_HEX   = BASE_BITS'(16);
  localparam logic [BASE_BITS-1:0] BASE_MIN   = BASE_BITS'(2);
  localparam logic [BASE_BITS-1:0] BASE_MAX   = BASE_BITS'(36);
  localparam logic [BASE_BITS-1:0] BASE_AUTO  = BASE_BITS'(0);
  localparam logic [BASE_BITS-1:0] BASE_UNARY = BASE_BITS'(1);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CHAR_BITS-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_LO_Z  = 8'h7a;
  localparam logic [CHAR_BITS-1:0] DIGIT_NONE = 8'hff;
  localparam logic [CHAR_BITS-1:0] LETTER_OFS = 8'd10;

  typedef enum logic [5:0] {
    PH_WS      = 6'b000001,
    PH_SIGNED  = 6'b000010,
    PH_ZERO    = 6'b000100,
    PH_DIGITS  = 6'b001000,
    PH_DONE    = 6'b010000,
    PH_BADBASE = 6'b100000
  } phase_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_NOCONV   = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BADBASE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  value;
    logic [OFFSET_BITS-1:0] end_offset;
    status_e                status;
  } result_t;

  // Digit value 0..35 of a character, DIGIT_NONE for anything else.
  function automatic logic [CHAR_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - CH_UP_A + LETTER_OFS;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - CH_LO_A + LETTER_OFS;
    end else begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

endpackage

/* src/auip_step.sv */
// Per-string parse state and the combinational character step.
module auip_step (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  logic [auip_pkg::CHAR_BITS-1:0]  char_i,
  input  logic [auip_pkg::BASE_BITS-1:0]  number_base_i,
  output logic                            emit_o,
  output auip_pkg::result_t               result_o
);
  import auip_pkg::*;

  phase_e                 phase_q, phase_d, ph_cur;
  logic                   neg_q, neg_d;
  logic                   zero_seen_q, zero_seen_d;
  logic                   have_q, have_d;
  logic                   ovf_q, ovf_d;
  logic [BASE_BITS-1:0]   base_q, base_d, base_cur, tb;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, ds_q, ds_d, stop_q, stop_d;

  logic                   at_start, is_term, is_ws, start, take, digit_ok;
  logic [CHAR_BITS-1:0]   dig;
  logic [PROD_BITS-1:0]   prod;
  logic [OFFSET_BITS-1:0] endpos;

  assign at_start = (phase_q == PH_WS) && (pos_q == '0);
  assign base_cur = at_start ? number_base_i : base_q;
  assign ph_cur   = (at_start && (number_base_i == BASE_UNARY || number_base_i > BASE_MAX))
                    ? PH_BADBASE : phase_q;
  assign is_term  = (char_i == CH_NUL);
  assign is_ws    = (char_i >= CH_TAB && char_i <= CH_CR) || (char_i == CH_SPACE);

  // Resolve an auto base: octal after a leading zero, decimal otherwise.
  assign tb       = (base_cur == BASE_AUTO) ? ((ph_cur == PH_ZERO) ? BASE_OCT : BASE_DEC)
                                            : base_cur;
  assign dig      = digit_of(char_i);
  assign digit_ok = (tb >= BASE_MIN) && (dig < {{(CHAR_BITS-BASE_BITS){1'b0}}, tb});
  assign prod     = PROD_BITS'(acc_q) * PROD_BITS'(tb)
                  + PROD_BITS'(dig[BASE_BITS-1:0]);
  assign endpos   = (ph_cur == PH_DONE) ? stop_q : pos_q;

  always_comb begin
    phase_d     = ph_cur;
    neg_d       = neg_q;
    zero_seen_d = zero_seen_q;
    have_d      = have_q;
    ovf_d       = ovf_q;
    base_d      = base_cur;
    acc_d       = acc_q;
    pos_d       = pos_q;
    ds_d        = ds_q;
    stop_d      = stop_q;
    start       = 1'b0;
    take        = 1'b0;
    emit_o      = 1'b0;
    result_o.value      = '0;
    result_o.end_offset = '0;
    result_o.status     = ST_NOCONV;

    if (fire_i && is_term) begin
      emit_o = 1'b1;
      unique case (ph_cur)
        PH_BADBASE: result_o.status = ST_BADBASE;
        PH_ZERO: begin
          result_o.end_offset = pos_q;
          result_o.status     = ST_OK;
        end
        PH_DIGITS, PH_DONE: begin
          if (have_q) begin
            result_o.end_offset = endpos;
            if (ovf_q) begin
              result_o.value  = '1;
              result_o.status = ST_OVERFLOW;
            end else begin
              result_o.value  = neg_q ? ('0 - acc_q) : acc_q;
              result_o.status = ST_OK;
            end
          end else if (zero_seen_q) begin
            result_o.end_offset = ds_q;
            result_o.status     = ST_OK;
          end
        end
        default: result_o.status = ST_NOCONV;
      endcase
      // Drop all per-string state for the next string.
      phase_d     = PH_WS;
      neg_d       = 1'b0;
      zero_seen_d = 1'b0;
      have_d      = 1'b0;
      ovf_d       = 1'b0;
      base_d      = '0;
      acc_d       = '0;
      pos_d       = '0;
      ds_d        = '0;
      stop_d      = '0;
    end else if (fire_i) begin
      unique case (ph_cur)
        PH_WS: begin
          if (is_ws) begin
            phase_d = PH_WS;
          end else if (char_i == CH_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_SIGNED;
          end else if (char_i == CH_PLUS) begin
            phase_d = PH_SIGNED;
          end else begin
            start = 1'b1;
          end
        end
        PH_SIGNED: start = 1'b1;
        PH_ZERO: begin
          if (char_i == CH_LO_X || char_i == CH_UP_X) begin
            zero_seen_d = 1'b1;
            ds_d        = pos_q;
            base_d      = BASE_HEX;
            phase_d     = PH_DIGITS;
          end else begin
            base_d  = tb;
            have_d  = 1'b1;
            phase_d = PH_DIGITS;
            take    = 1'b1;
          end
        end
        PH_DIGITS: take = 1'b1;
        default: phase_d = ph_cur;
      endcase

      if (start) begin
        if (char_i == CH_ZERO && (base_cur == BASE_AUTO || base_cur == BASE_HEX)) begin
          phase_d = PH_ZERO;
        end else begin
          base_d  = tb;
          phase_d = PH_DIGITS;
          take    = 1'b1;
        end
      end

      if (take) begin
        if (!digit_ok) begin
          stop_d  = pos_q;
          phase_d = PH_DONE;
        end else begin
          have_d = 1'b1;
          if (|prod[PROD_BITS-1:VALUE_BITS]) begin
            ovf_d = 1'b1;
          end else begin
            acc_d = prod[VALUE_BITS-1:0];
          end
        end
      end

      if (pos_q != OFF_MAX) begin
        pos_d = pos_q + OFFSET_BITS'(1);
      end
    end else begin
      base_d = base_q;
      phase_d = phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WS;
      neg_q       <= 1'b0;
      zero_seen_q <= 1'b0;
      have_q      <= 1'b0;
      ovf_q       <= 1'b0;
      base_q      <= '0;
      acc_q       <= '0;
      pos_q       <= '0;
      ds_q        <= '0;
      stop_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      zero_seen_q <= zero_seen_d;
      have_q      <= have_d;
      ovf_q       <= ovf_d;
      base_q      <= base_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      ds_q        <= ds_d;
      stop_q      <= stop_d;
    end
  end

endmodule

/* src/auip_out_reg.sv */
// Result register with valid/ready toward the consumer.
module auip_out_reg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  auip_pkg::result_t                 result_i,
  output logic                              free_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [auip_pkg::VALUE_BITS-1:0]   value_o,
  output logic [auip_pkg::OFFSET_BITS-1:0]  end_offset_o,
  output logic [auip_pkg::STATUS_BITS-1:0]  status_o
);
  import auip_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign value_o      = res_q.value;
  assign end_offset_o = res_q.end_offset;
  assign status_o     = STATUS_BITS'(res_q.status);

endmodule

/* src/ascii_unsigned_integer_parser.sv */
// Top level of the streaming ASCII to unsigned integer parser.
//
//   channel   signals                                   direction
//   -------   ---------------------------------------   ---------
//   config    cfg_valid_i, cfg_ready_o, cfg_number_base_i   in
//   input     in_valid_i, in_ready_o, char_in_i              in
//   result    out_valid_o, out_ready_i, value_o,             out
//             end_offset_o, status_o
//
// One character is taken per cycle unless a terminator waits on a full result
// register. A character is held in the input register, then one short step (a
// 64x6 multiply-add with overflow check) updates the parse state; a zero byte
// loads the result register, which then shows the result. Reset (rst_ni low, async)
// returns the parse state to the start of a string and the base to 10.
// Only a terminator waits on a full result register; other characters keep
// flowing while a result is held.
module ascii_unsigned_integer_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [auip_pkg::BASE_BITS-1:0]    cfg_number_base_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [auip_pkg::CHAR_BITS-1:0]    char_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [auip_pkg::VALUE_BITS-1:0]   value_o,
  output logic [auip_pkg::OFFSET_BITS-1:0]  end_offset_o,
  output logic [auip_pkg::STATUS_BITS-1:0]  status_o
);
  import auip_pkg::*;

  logic [BASE_BITS-1:0] number_base_q;
  logic                 s1_valid_q;
  logic [CHAR_BITS-1:0] s1_char_q;
  logic                 s1_fire, out_free, emit;
  result_t              step_res;

  // Base register: always writable; the parser samples it at a string's first byte.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BASE_RESET;
    end else if (cfg_valid_i) begin
      number_base_q <= cfg_number_base_i;
    end
  end

  // Advance the held character unless it is a terminator and the result slot is busy.
  assign s1_fire    = s1_valid_q && ((s1_char_q != CH_NUL) || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Hold the character payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_char_q <= char_in_i;
    end
  end

  auip_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (s1_fire),
    .char_i        (s1_char_q),
    .number_base_i (number_base_q),
    .emit_o        (emit),
    .result_o      (step_res)
  );

  auip_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (emit),
    .result_i     (step_res),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .end_offset_o (end_offset_o),
    .status_o     (status_o)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench of the streaming ASCII to unsigned integer parser.
`timescale 1ns / 1ps

module tb;
  import auip_pkg::*;

  // Clock, reset and the ports of the block; the driven inputs are known from time zero
  logic                   clk_i             = 1'b0;
  logic                   rst_ni            = 1'b0;
  logic                   cfg_valid_i       = 1'b0;
  logic                   cfg_ready_o;
  logic [BASE_BITS-1:0]   cfg_number_base_i = '0;
  logic                   in_valid_i        = 1'b0;
  logic                   in_ready_o;
  logic [CHAR_BITS-1:0]   char_in_i         = '0;
  logic                   out_valid_o;
  logic                   out_ready_i       = 1'b0;
  logic [VALUE_BITS-1:0]  value_o;
  logic [OFFSET_BITS-1:0] end_offset_o;
  logic [STATUS_BITS-1:0] status_o;

  ascii_unsigned_integer_parser uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_number_base_i(cfg_number_base_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_in_i        (char_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_o          (value_o),
    .end_offset_o     (end_offset_o),
    .status_o         (status_o)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parse predictor: own copy of the base register and the per-string state
  // ---------------------------------------------------------------------------
  logic [BASE_BITS-1:0]   base_reg;      // programmed base
  phase_e                 scan_phase;
  logic                   neg_sign;
  logic                   hex_prefix;    // a 0x prefix was taken
  logic                   got_digit;
  logic [BASE_BITS-1:0]   run_base;      // base in force for this string
  logic [VALUE_BITS-1:0]  acc_value;
  logic                   acc_overflow;
  logic [OFFSET_BITS-1:0] char_pos;
  logic [OFFSET_BITS-1:0] x_pos;         // offset of the 'x' of a prefix
  logic [OFFSET_BITS-1:0] stop_pos;

  result_t pending_results[$];           // expected results, oldest first

  // Directed rows may override the predicted result with a typed-in one
  logic    typed_on = 1'b0;
  result_t typed_res;

  int errors    = 0;
  int n_chars   = 0;
  int n_results = 0;
  int n_cfg     = 0;
  int st_count[4];
  logic quiet   = 1'b0;                  // no gaps and no stalls while set

  task automatic clear_scan();
    scan_phase   = PH_WS;
    neg_sign     = 1'b0;
    hex_prefix   = 1'b0;
    got_digit    = 1'b0;
    run_base     = BASE_AUTO;
    acc_value    = '0;
    acc_overflow = 1'b0;
    char_pos     = '0;
    x_pos        = '0;
    stop_pos     = '0;
  endtask

  function automatic logic [CHAR_BITS-1:0] digit_value(logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] dv;
    dv = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      dv = c - CH_ZERO;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      dv = c - CH_UP_A + 8'd10;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      dv = c - CH_LO_A + 8'd10;
    end
    return dv;
  endfunction

  // Accumulate one digit, or mark the end of the digit run
  task automatic eat_digit(logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] dv;
    logic [PROD_BITS-1:0] prod;
    dv = digit_value(c);
    if (run_base < BASE_MIN || dv >= run_base) begin
      stop_pos   = char_pos;
      scan_phase = PH_DONE;
    end else begin
      got_digit = 1'b1;
      // overflow when the wide product spills above the value width
      prod = PROD_BITS'(acc_value) * PROD_BITS'(run_base) + PROD_BITS'(dv);
      if (prod[PROD_BITS-1:VALUE_BITS] != '0) begin
        acc_overflow = 1'b1;
      end else begin
        acc_value = prod[VALUE_BITS-1:0];
      end
    end
  endtask

  task automatic begin_number(logic [CHAR_BITS-1:0] c);
    if (c == CH_ZERO && (run_base == BASE_AUTO || run_base == BASE_HEX)) begin
      scan_phase = PH_ZERO;
    end else begin
      if (run_base == BASE_AUTO) run_base = BASE_DEC;
      scan_phase = PH_DIGITS;
      eat_digit(c);
    end
  endtask

  // Advance the predictor by one accepted character; a terminator queues a result
  task automatic scan_char(logic [CHAR_BITS-1:0] c);
    result_t                res;
    logic [OFFSET_BITS-1:0] endp;
    logic                   is_space;
    if (scan_phase == PH_WS && char_pos == '0) begin
      run_base = base_reg;
      if (run_base == BASE_UNARY || run_base > BASE_MAX) scan_phase = PH_BADBASE;
    end
    if (c == CH_NUL) begin
      res.value      = '0;
      res.end_offset = '0;
      res.status     = ST_NOCONV;
      case (scan_phase)
        PH_BADBASE: res.status = ST_BADBASE;
        PH_ZERO: begin
          res.end_offset = char_pos;
          res.status     = ST_OK;
        end
        PH_DIGITS, PH_DONE: begin
          endp = (scan_phase == PH_DONE) ? stop_pos : char_pos;
          if (got_digit) begin
            res.end_offset = endp;
            if (acc_overflow) begin
              res.value  = '1;
              res.status = ST_OVERFLOW;
            end else begin
              res.value  = neg_sign ? VALUE_BITS'(0) - acc_value : acc_value;
              res.status = ST_OK;
            end
          end else if (hex_prefix) begin
            // bare prefix: only the '0' converts
            res.end_offset = x_pos;
            res.status     = ST_OK;
          end
        end
        default: ;
      endcase
      pending_results.push_back(typed_on ? typed_res : res);
      clear_scan();
    end else begin
      is_space = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
      case (scan_phase)
        PH_WS: begin
          if (c == CH_MINUS) begin
            neg_sign   = 1'b1;
            scan_phase = PH_SIGNED;
          end else if (c == CH_PLUS) begin
            scan_phase = PH_SIGNED;
          end else if (!is_space) begin
            begin_number(c);
          end
        end
        PH_SIGNED: begin_number(c);
        PH_ZERO: begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            hex_prefix = 1'b1;
            x_pos      = char_pos;
            run_base   = BASE_HEX;
            scan_phase = PH_DIGITS;
          end else begin
            if (run_base == BASE_AUTO) run_base = BASE_OCT;
            got_digit  = 1'b1;
            acc_value  = '0;
            scan_phase = PH_DIGITS;
            eat_digit(c);
          end
        end
        PH_DIGITS: eat_digit(c);
        default: ;
      endcase
      if (char_pos != OFF_MAX) char_pos = char_pos + OFFSET_BITS'(1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Offer one character request; hold it until accepted, then advance the predictor
  task automatic send_char(logic [CHAR_BITS-1:0] c);
    int g;
    g = quiet ? 0 : pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    scan_char(c);
    n_chars++;
  endtask

  // Drop the input request and wait until every expected result has come or the guard runs out
  task automatic drain(int settle);
    int guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (settle) @(posedge clk_i);
  endtask

  // Program the base; only done with the block idle
  task automatic write_base(logic [BASE_BITS-1:0] b);
    drain(4);
    cfg_valid_i       <= 1'b1;
    cfg_number_base_i <= b;
    do @(posedge clk_i); while (!cfg_ready_o);
    base_reg = b;
    n_cfg++;
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, and compare each result with the oldest expectation
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk_i) begin : ready_gen
    int g;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      g = quiet ? 0 : pick_gap();
      out_ready_i <= (g == 0);
      stall_left  <= (g > 0) ? g - 1 : 0;
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t exp_r;
    if (out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: value %h offset %0d status %0d",
                 $time, value_o, end_offset_o, status_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        st_count[exp_r.status]++;
        if (value_o !== exp_r.value) begin
          $display("%0t: value expected %h actual %h", $time, exp_r.value, value_o);
          errors++;
        end
        if (end_offset_o !== exp_r.end_offset) begin
          $display("%0t: end_offset expected %0d actual %0d",
                   $time, exp_r.end_offset, end_offset_o);
          errors++;
        end
        if (status_o !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [BASE_BITS-1:0]   base;
    string                  txt;
    logic                   add_ff;     // append byte 255 before the terminator
    logic                   typed;      // use the typed-in result below
    logic [VALUE_BITS-1:0]  value;
    logic [OFFSET_BITS-1:0] offset;
    status_e                status;
  } dir_row_t;

  dir_row_t rows[7];

  logic [BASE_BITS-1:0] base_plan[9] = '{BASE_DEC, BASE_AUTO, BASE_HEX, BASE_MIN,
                                         BASE_MAX, BASE_OCT, BASE_UNARY, 6'd37, 6'd63};

  logic [CHAR_BITS-1:0] str_buf[$];

  initial begin : stimulus
    int                    k;
    int                    eff;
    int                    style;
    int                    lim;
    int                    n_dig;
    int                    d;
    int                    plan_idx;
    int                    random_start;
    logic                  all_max;
    logic [VALUE_BITS-1:0] big;
    logic [BASE_BITS-1:0]  nb;

    foreach (st_count[i]) st_count[i] = 0;
    base_reg = BASE_RESET;
    clear_scan();

    // Directed rows: reset state, sign and whitespace, bare prefix, base detection,
    // octal stop, invalid base, overflow at the largest base, byte extremes
    rows[0] = '{BASE_DEC, "", 1'b0, 1'b1, '0, '0, ST_NOCONV};
    rows[1] = '{BASE_DEC, "\t-9", 1'b1, 1'b0, '0, '0, ST_OK};
    rows[2] = '{BASE_HEX, "0x", 1'b0, 1'b1, '0, 16'd1, ST_OK};
    rows[3] = '{BASE_AUTO, "0Xf", 1'b0, 1'b0, '0, '0, ST_OK};
    rows[4] = '{BASE_AUTO, "08", 1'b0, 1'b0, '0, '0, ST_OK};
    rows[5] = '{BASE_UNARY, "5", 1'b0, 1'b1, '0, '0, ST_BADBASE};
    rows[6] = '{BASE_MAX, "zzzzzzzzzzzzz", 1'b0, 1'b1, '1, 16'd13, ST_OVERFLOW};

    // Hold reset, then release it on a rising edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      // the first row runs with the base left by reset
      if (rows[i].base != base_reg) write_base(rows[i].base);
      typed_on  = rows[i].typed;
      typed_res = '{value: rows[i].value, end_offset: rows[i].offset,
                    status: rows[i].status};
      for (k = 0; k < rows[i].txt.len(); k++) send_char(rows[i].txt[k]);
      if (rows[i].add_ff) send_char(8'hff);
      send_char(CH_NUL);
      typed_on = 1'b0;
    end

    // Random part: phases of one base each, first the planned bases, then random ones
    plan_idx     = 0;
    random_start = n_chars;
    while (n_chars - random_start < 1600) begin
      if (plan_idx < 9) begin
        nb = base_plan[plan_idx];
      end else begin
        k = $urandom_range(0, 9);
        if (k < 7) nb = BASE_BITS'($urandom_range(2, 36));
        else if (k < 9) nb = BASE_AUTO;
        else nb = BASE_BITS'($urandom_range(0, 63));
      end
      plan_idx++;
      write_base(nb);
      quiet = ($urandom_range(0, 4) == 0);

      repeat ($urandom_range(10, 30)) begin
        str_buf.delete();
        if ($urandom_range(0, 3) == 0) begin
          // noise: arbitrary nonzero bytes
          repeat ($urandom_range(0, 6)) str_buf.push_back(CHAR_BITS'($urandom_range(1, 255)));
        end else begin
          // well-formed number: whitespace, sign, prefix, digits, optional trailer
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              k = $urandom_range(0, 5);
              str_buf.push_back(k == 5 ? CH_SPACE : CHAR_BITS'(CH_TAB + k));
            end
          end
          k = $urandom_range(0, 3);
          if (k == 0) str_buf.push_back(CH_MINUS);
          else if (k == 1) str_buf.push_back(CH_PLUS);

          eff = (base_reg == BASE_UNARY || base_reg > BASE_MAX) ? 10 : int'(base_reg);
          style = $urandom_range(0, 2);
          if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && style == 0) begin
            str_buf.push_back(CH_ZERO);
            str_buf.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            eff = 16;
          end else if (base_reg == BASE_AUTO && style == 1) begin
            str_buf.push_back(CH_ZERO);
            eff = 8;
          end else if (base_reg == BASE_AUTO) begin
            eff = 10;
          end

          // digit count of the all-ones value in this base, to aim at the overflow edge
          lim = 0;
          big = '1;
          while (big != 0) begin
            big = big / eff;
            lim++;
          end
          k       = $urandom_range(0, 9);
          n_dig   = (k == 0) ? 0 : (k < 7) ? $urandom_range(1, 4) : $urandom_range(lim - 1, lim + 1);
          all_max = (k >= 7) && ($urandom_range(0, 1) == 1);
          repeat (n_dig) begin
            d = all_max ? eff - 1 : $urandom_range(0, eff - 1);
            if (d < 10) str_buf.push_back(CHAR_BITS'(CH_ZERO + d));
            else str_buf.push_back(CHAR_BITS'(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + d - 10));
          end
          if ($urandom_range(0, 1)) str_buf.push_back(CHAR_BITS'($urandom_range(1, 255)));
        end
        str_buf.push_back(CH_NUL);
        foreach (str_buf[j]) send_char(str_buf[j]);
      end
    end

    // Wait out the last results, then let the pipeline settle
    drain(10);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors += pending_results.size();
    end

    $display("Run covered %0d characters, %0d results, %0d base writes",
             n_chars, n_results, n_cfg);
    $display("Result mix: ok %0d, no conversion %0d, overflow %0d, invalid base %0d",
             st_count[ST_OK], st_count[ST_NOCONV], st_count[ST_OVERFLOW],
             st_count[ST_BADBASE]);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
